### hdl/block_rms_level_meter_assert.svh
// Assertion macros used by the checker file of the level meter.
`ifndef BLOCK_RMS_LEVEL_METER_ASSERT_SVH
`define BLOCK_RMS_LEVEL_METER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge and silent during reset.
`define BRMS_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("level meter check failed");

// Next-cycle implication, sampled on the rising clock edge and silent during reset.
`define BRMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("level meter check failed");

`endif

### hdl/brms_pkg.sv
`timescale 1ns / 1ps

package brms_pkg;

	localparam int MAX_BLOCK_SAMPLES = 4096;
	localparam int TOTAL_W = $clog2(MAX_BLOCK_SAMPLES + 1);
	// Sum of squares: each square is at most 2**30.
	localparam int SUM_W = 31 + $clog2(MAX_BLOCK_SAMPLES) + 1;
	localparam int EXP_W = $clog2(SUM_W);
	localparam int LOG_W = EXP_W + 16;
	localparam int T_W = LOG_W + 2;
	localparam int NEGT_W = LOG_W + 1;
	localparam int SCALE_W = 27 + NEGT_W;

	localparam logic [14:0] VOL_MAX = 15'd25600;
	localparam logic [31:0] DB_SLOPE_Q16 = 32'd84174088;
	localparam logic [T_W-1:0] LOG2_FULL_SCALE_SQ = T_W'(30 * 65536);
	localparam logic [15:0] OFFSET_MID = 16'h8000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_NORM,
		ST_FRAC,
		ST_DIFF,
		ST_SCALE,
		ST_ROUND,
		ST_EMIT
	} state_t;

endpackage

### hdl/block_rms_level_meter.sv
`timescale 1ns / 1ps

// Channel   Handshake          Payload
// s_*       s_tvalid/s_tready  s_tdata[15:0] sample_word, s_tlast last_of_block
// m_*       m_tvalid/m_tready  m_tdata[14:0] volume_level, bit 15 zero
// cfg_*     cfg_wr_en          cfg_wr_data sample_mode
//
// Each sample is captured, then squared and accumulated on the shared multiplier.
// A last sample is normalised and its log fraction found for the sum and then the count,
// then the difference, dB scaling and rounding (below full scale) lead to the emit state.
// The 44-bit shift runs one bit a cycle; each of 16 fraction bits takes a multiplier pass.
// Reset clears the accumulators and the mode; the result register frees s_tready while a
// volume beat waits, and only the next result waits on m_tready.

module block_rms_level_meter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,  // sample_mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,      // [15:0] sample_word
	input  logic        s_tlast,      // last_of_block
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata       // [14:0] volume_level, [15] zero
);

	localparam int SW = brms_pkg::SUM_W;

	brms_pkg::state_t state_q, state_next;

	logic                            mode_q;
	logic [SW-1:0]                   sum_q;
	logic [brms_pkg::TOTAL_W-1:0]    total_q;
	logic                            out_valid_q;
	logic [14:0]                     out_data_q;

	logic [15:0]                     mag_q;
	logic                            last_q;
	logic [SW-1:0]                   norm_q;
	logic [brms_pkg::EXP_W-1:0]      exp_q;
	logic [31:0]                     m_q;
	logic [14:0]                     frac_q;
	logic [3:0]                      iter_q;
	logic                            sel_n_q;
	logic [brms_pkg::LOG_W-1:0]      log_s_q;
	logic [brms_pkg::LOG_W-1:0]      log_n_q;
	logic [brms_pkg::NEGT_W-1:0]     negt_q;
	logic [brms_pkg::SCALE_W-1:0]    prod_q;
	logic [14:0]                     vol_q;

	logic [15:0]                     mag;
	logic                            block_full;
	logic                            in_beat;
	logic [31:0]                     mul_a, mul_b;
	logic [63:0]                     prod;
	logic [SW-1:0]                   sum_next;
	logic [32:0]                     sq_shift;
	logic                            frac_bit;
	logic [31:0]                     m_next;
	logic [brms_pkg::LOG_W-1:0]      log_cur;
	logic [brms_pkg::T_W-1:0]        t_val;
	logic [brms_pkg::T_W-1:0]        t_mag;
	logic [brms_pkg::SCALE_W:0]      round_sum;
	logic [brms_pkg::SCALE_W-32:0]   dec;
	logic                            emit_go;

	assign block_full = (total_q == brms_pkg::TOTAL_W'(brms_pkg::MAX_BLOCK_SAMPLES));

	brms_mag u_mag (
		.sample_mode (mode_q),
		.block_full  (block_full),
		.sample_word (s_tdata),
		.mag         (mag)
	);

	assign in_beat = s_tvalid && s_tready;

	// The one multiplier serves squaring, the log iterations and the dB scaling.
	assign prod     = mul_a * mul_b;
	assign sum_next = sum_q + SW'(prod[30:0]);
	assign sq_shift = prod[63:31];
	assign frac_bit = sq_shift[32];
	assign m_next   = frac_bit ? sq_shift[32:1] : sq_shift[31:0];
	assign log_cur  = {exp_q, frac_q, frac_bit};

	assign t_val = {2'b00, log_s_q} - {2'b00, log_n_q} - brms_pkg::LOG2_FULL_SCALE_SQ;
	assign t_mag = -t_val;

	assign round_sum = {1'b0, prod_q} + (brms_pkg::SCALE_W + 1)'(64'h8000_0000);
	assign dec       = round_sum[brms_pkg::SCALE_W:32];

	assign emit_go = !out_valid_q || m_tready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			brms_pkg::ST_IDLE: begin
				if (s_tvalid) state_next = brms_pkg::ST_SQUARE;
			end
			brms_pkg::ST_SQUARE: begin
				if (!last_q) begin
					state_next = brms_pkg::ST_IDLE;
				end else if (sum_next == '0 || total_q == '0) begin
					state_next = brms_pkg::ST_EMIT;
				end else begin
					state_next = brms_pkg::ST_NORM;
				end
			end
			brms_pkg::ST_NORM: begin
				if (norm_q[SW-1]) state_next = brms_pkg::ST_FRAC;
			end
			brms_pkg::ST_FRAC: begin
				if (iter_q == 4'd15) begin
					state_next = sel_n_q ? brms_pkg::ST_DIFF : brms_pkg::ST_NORM;
				end
			end
			brms_pkg::ST_DIFF: begin
				state_next = t_val[brms_pkg::T_W-1] ? brms_pkg::ST_SCALE : brms_pkg::ST_EMIT;
			end
			brms_pkg::ST_SCALE: state_next = brms_pkg::ST_ROUND;
			brms_pkg::ST_ROUND: state_next = brms_pkg::ST_EMIT;
			brms_pkg::ST_EMIT: begin
				if (emit_go) state_next = brms_pkg::ST_IDLE;
			end
			default: state_next = brms_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			brms_pkg::ST_IDLE: s_tready = 1'b1;
			brms_pkg::ST_SQUARE: begin
				mul_a = {16'd0, mag_q};
				mul_b = {16'd0, mag_q};
			end
			brms_pkg::ST_FRAC: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			brms_pkg::ST_SCALE: begin
				mul_a = brms_pkg::DB_SLOPE_Q16;
				mul_b = 32'(negt_q);
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brms_pkg::ST_IDLE;
			mode_q      <= 1'b0;
			sum_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_wr_en) mode_q <= cfg_wr_data;
			if (in_beat && !block_full) total_q <= total_q + 1'b1;
			if (state_q == brms_pkg::ST_SQUARE) sum_q <= sum_next;
			if (state_q == brms_pkg::ST_EMIT && emit_go) begin
				sum_q       <= '0;
				total_q     <= '0;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			mag_q  <= mag;
			last_q <= s_tlast;
		end
		case (state_q)
			brms_pkg::ST_SQUARE: begin
				vol_q   <= '0;
				norm_q  <= sum_next;
				exp_q   <= brms_pkg::EXP_W'(SW - 1);
				sel_n_q <= 1'b0;
			end
			brms_pkg::ST_NORM: begin
				iter_q <= '0;
				frac_q <= '0;
				m_q    <= norm_q[SW-1 -: 32];
				if (!norm_q[SW-1]) begin
					norm_q <= {norm_q[SW-2:0], 1'b0};
					exp_q  <= exp_q - 1'b1;
				end
			end
			brms_pkg::ST_FRAC: begin
				m_q    <= m_next;
				frac_q <= {frac_q[13:0], frac_bit};
				iter_q <= iter_q + 1'b1;
				if (iter_q == 4'd15) begin
					if (sel_n_q) begin
						log_n_q <= log_cur;
					end else begin
						log_s_q <= log_cur;
						norm_q  <= SW'(total_q);
						exp_q   <= brms_pkg::EXP_W'(SW - 1);
						sel_n_q <= 1'b1;
					end
				end
			end
			brms_pkg::ST_DIFF: begin
				vol_q  <= brms_pkg::VOL_MAX;
				negt_q <= t_mag[brms_pkg::NEGT_W-1:0];
			end
			brms_pkg::ST_SCALE: prod_q <= prod[brms_pkg::SCALE_W-1:0];
			brms_pkg::ST_ROUND: begin
				if (dec >= (brms_pkg::SCALE_W - 31)'(brms_pkg::VOL_MAX)) begin
					vol_q <= '0;
				end else begin
					vol_q <= brms_pkg::VOL_MAX - dec[14:0];
				end
			end
			brms_pkg::ST_EMIT: begin
				if (emit_go) out_data_q <= vol_q;
			end
			default: begin
				iter_q <= iter_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_data_q};

endmodule

### hdl/brms_mag.sv
`timescale 1ns / 1ps

module brms_mag (
	input  logic        sample_mode,
	input  logic        block_full,
	input  logic [15:0] sample_word,
	output logic [15:0] mag
);

	logic [15:0] raw_mag;

	always_comb begin
		if (sample_mode) begin
			if (sample_word >= brms_pkg::OFFSET_MID) begin
				raw_mag = sample_word - brms_pkg::OFFSET_MID;
			end else begin
				raw_mag = brms_pkg::OFFSET_MID - sample_word;
			end
		end else begin
			if (sample_word[15]) begin
				// The most negative word gives 32768, which still fits.
				raw_mag = 16'(17'h10000 - {1'b0, sample_word});
			end else begin
				raw_mag = sample_word;
			end
		end
	end

	// A sample past the block limit contributes nothing.
	assign mag = block_full ? 16'd0 : raw_mag;

endmodule

### hdl/brms_checker.sv
`timescale 1ns / 1ps

`include "block_rms_level_meter_assert.svh"

module brms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result beat stays offered and unchanged.
	`BRMS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`BRMS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

	// The volume never exceeds full scale.
	`BRMS_ASSERT_IMPLY(a_vol_range, m_tvalid, !m_tdata[15] && m_tdata[14:0] <= 15'd25600)

	// Each sample beat occupies the multiplier for the following cycle.
	`BRMS_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready)

	// A sample that is not last never produces a volume beat.
	`BRMS_ASSERT_NEXT(a_no_spurious_out, s_tvalid && s_tready && !s_tlast && !m_tvalid, !m_tvalid)

endmodule

bind block_rms_level_meter brms_checker u_brms_checker (.*);
